@@ sv/rgb_to_hsl_convert_unit_assert.svh @@
// Assertion macros for the RGB to HSL converter checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef RGB_TO_HSL_CONVERT_UNIT_ASSERT_SVH
`define RGB_TO_HSL_CONVERT_UNIT_ASSERT_SVH

// checked out of reset only
`define RHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define RHC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/rgbhsl_pkg.sv @@
// Types and constants for the RGB to HSL converter pipeline.
// No dependencies.
package rgbhsl_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned HueDenW  = 11;  // 6 * delta, up to 1530
  localparam int unsigned SatDenW  = 8;   // saturation divisor, up to 255
  localparam int unsigned QuotW    = 17;  // integer bit plus 16 fraction bits
  localparam int unsigned SumW     = 9;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned NumStg   = QuotW + 1;

  typedef struct packed {
    logic [HueDenW-1:0] hrem;
    logic [HueDenW-1:0] hden;
    logic [QuotW-1:0]   hq;
    logic [SatDenW-1:0] srem;
    logic [SatDenW-1:0] sden;
    logic [QuotW-1:0]   sq;
    logic               grey;
    logic [SumW-1:0]    sum;
    logic [ChanW-1:0]   alpha;
  } stage_t;

endpackage

@@ sv/rgb_to_hsl_convert_unit.sv @@
// RGB to HSL converter: front stage finds max/min, then two restoring dividers
// run one quotient bit per stage side by side. Depends on rgbhsl_pkg.
//
//  channel   dir  tdata fields (low bit up)                          rate
//  s_axis    in   red, green, blue, alpha_in                        1 word/clk
//  m_axis    out  hue, saturation, lightness_sum, alpha_out, pad     1 word/clk
//
// One word per clock sustained while the sink is ready; 18 register stages from accept to result,
// set by the 17 quotient-bit steps of the dividers plus the max/min stage.
// Reset clears every stage valid bit; payload registers are not reset.
// Each full stage holds when the one after it is full and stalled, so a stall
// lets bubbles close up and loses or repeats nothing.
module rgb_to_hsl_convert_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha_in
  input  logic [rgbhsl_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [15:0] hue, [31:16] saturation, [40:32] lightness_sum, [48:41] alpha_out,
  // [55:49] zero
  output logic [rgbhsl_pkg::OutDataW-1:0]    m_axis_tdata
);
  import rgbhsl_pkg::*;

  function automatic stage_t div_step(input stage_t s, input logic first);
    logic [HueDenW:0] hsh;
    logic [SatDenW:0] ssh;
    logic             hge;
    logic             sge;
    logic [HueDenW:0] hnew;
    logic [SatDenW:0] snew;
    stage_t           o;
    o    = s;
    hsh  = first ? {1'b0, s.hrem} : {s.hrem, 1'b0};
    ssh  = first ? {1'b0, s.srem} : {s.srem, 1'b0};
    hge  = hsh >= {1'b0, s.hden};
    sge  = ssh >= {1'b0, s.sden};
    hnew = hge ? hsh - {1'b0, s.hden} : hsh;
    snew = sge ? ssh - {1'b0, s.sden} : ssh;
    o.hrem = hnew[HueDenW-1:0];
    o.srem = snew[SatDenW-1:0];
    o.hq   = {s.hq[QuotW-2:0], hge};
    o.sq   = {s.sq[QuotW-2:0], sge};
    return o;
  endfunction

  logic [ChanW-1:0]   red, green, blue, alpha_in;
  logic               green_max, blue_max;
  logic [ChanW-1:0]   mx1, mx, mn1, mn, dlt;
  logic [SumW-1:0]    sum;
  logic [SumW-1:0]    sat_den;
  logic [HueDenW-1:0] d1, d2, d4, d6, hnum;
  stage_t             front_d;

  stage_t             st_q [NumStg];
  stage_t             st_d [NumStg];
  logic [NumStg-1:0]  vld_q;
  logic [NumStg-1:0]  vld_in;
  logic               rdy [NumStg];

  assign red      = s_axis_tdata[7:0];
  assign green    = s_axis_tdata[15:8];
  assign blue     = s_axis_tdata[23:16];
  assign alpha_in = s_axis_tdata[31:24];

  always_comb begin
    green_max = green > red;
    mx1       = green_max ? green : red;
    blue_max  = blue > mx1;
    mx        = blue_max ? blue : mx1;
    mn1       = (green < red) ? green : red;
    mn        = (blue < mn1) ? blue : mn1;
    dlt       = mx - mn;
    sum       = {1'b0, mx} + {1'b0, mn};
    sat_den   = (sum >= SumW'(255)) ? SumW'(510) - sum : sum;
    d1        = HueDenW'(dlt);
    d2        = d1 << 1;
    d4        = d1 << 2;
    d6        = d4 + d2;
    if (blue_max) begin
      hnum = d4 + HueDenW'(red) - HueDenW'(green);
    end else if (green_max) begin
      hnum = d2 + HueDenW'(blue) - HueDenW'(red);
    end else if (green >= blue) begin
      hnum = HueDenW'(green) - HueDenW'(blue);
    end else begin
      hnum = d6 - (HueDenW'(blue) - HueDenW'(green));
    end
    front_d.hrem  = hnum;
    front_d.hden  = d6;
    front_d.hq    = '0;
    front_d.srem  = dlt;
    front_d.sden  = sat_den[SatDenW-1:0];
    front_d.sq    = '0;
    front_d.grey  = (dlt == '0);
    front_d.sum   = sum;
    front_d.alpha = alpha_in;
  end

  assign st_d[0] = front_d;

  for (genvar k = 1; k < NumStg; k++) begin : g_div
    assign st_d[k] = div_step(st_q[k-1], (k == 1));
  end

  for (genvar k = 0; k < NumStg; k++) begin : g_stg
    if (k == NumStg - 1) begin : g_last
      assign rdy[k] = m_axis_tready || !vld_q[k];
    end else begin : g_mid
      assign rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign vld_in = {vld_q[NumStg-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStg; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStg; k++) begin
      if (rdy[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  stage_t          last;
  logic [15:0]     hue, saturation;

  assign last = st_q[NumStg-1];

  always_comb begin
    if (last.grey) begin
      hue        = '0;
      saturation = '0;
    end else begin
      hue        = last.hq[15:0];
      saturation = last.sq[QuotW-1] ? 16'hFFFF : last.sq[15:0];
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NumStg-1];
  assign m_axis_tdata  = {7'b0, last.alpha, last.sum, saturation, hue};

endmodule

@@ sv/rgbhsl_checker.sv @@
// Port-level checks for the RGB to HSL converter, bound to the top level.
// Depends on rgbhsl_pkg and rgb_to_hsl_convert_unit_assert.svh.
`include "rgb_to_hsl_convert_unit_assert.svh"

module rgbhsl_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rgbhsl_pkg::OutDataW-1:0] m_axis_tdata
);
  import rgbhsl_pkg::*;

  property p_out_hold;
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata);
  endproperty

  property p_grey_hue;
    m_axis_tvalid && (m_axis_tdata[31:16] == 16'h0) |-> (m_axis_tdata[15:0] == 16'h0);
  endproperty

  property p_sum_range;
    m_axis_tvalid |-> (m_axis_tdata[40:32] <= 9'd510) && (m_axis_tdata[55:49] == 7'h0);
  endproperty

  property p_empty_ready;
    !m_axis_tvalid |-> s_axis_tready;
  endproperty

  `RHC_ASSERT(a_out_hold, p_out_hold, "output word changed while stalled")
  `RHC_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !m_axis_tvalid, "output valid during reset")
  `RHC_ASSERT(a_grey_hue, p_grey_hue, "zero saturation with nonzero hue")
  `RHC_ASSERT(a_sum_range, p_sum_range, "lightness sum or padding out of range")
  `RHC_ASSERT(a_empty_ready, p_empty_ready, "input stalled with empty output")

endmodule

bind rgb_to_hsl_convert_unit rgbhsl_checker u_rgbhsl_checker (.*);

@@ tb/tb.sv @@
// Testbench for rgb_to_hsl_convert_unit: directed and random pixels under
// varied source idling and sink back-pressure, checked against a local HSL model.
// Depends on rgbhsl_pkg and rgb_to_hsl_convert_unit.
module tb;
  import rgbhsl_pkg::*;

  typedef enum logic [1:0] {TOP_RED, TOP_GREEN, TOP_BLUE} top_chan_e;

  typedef struct {
    logic [15:0]     hue;
    logic [15:0]     sat;
    logic [SumW-1:0] lsum;
    logic [7:0]      alpha;
  } hsl_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  logic [InDataW-1:0] pixel_q[$];
  hsl_t               hsl_q[$];
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_stall_pct = 0;
  int unsigned        err_cnt = 0;

  rgb_to_hsl_convert_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic hsl_t hsl_of(logic [InDataW-1:0] word);
    logic [7:0]  r, g, b;
    logic [7:0]  mx, mn;
    top_chan_e   top;
    int unsigned d, sum, n, den;
    longint unsigned q;
    hsl_t        res;
    r = word[7:0];
    g = word[15:8];
    b = word[23:16];
    mx = r;
    mn = r;
    top = TOP_RED;
    if (g > r) begin
      mx = g;
      top = TOP_GREEN;
    end
    if (b > mx) begin
      mx = b;
      top = TOP_BLUE;
    end
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    sum = mx + mn;
    res.hue = '0;
    res.sat = '0;
    res.lsum = sum[SumW-1:0];
    res.alpha = word[31:24];
    if (d != 0) begin
      case (top)
        TOP_RED:   n = (g >= b) ? (g - b) : (6 * d - (b - g));
        TOP_GREEN: n = 2 * d + b - r;
        default:   n = 4 * d + r - g;
      endcase
      q = (longint'(n) << 16) / (6 * d);
      res.hue = (q > 65535) ? 16'hFFFF : q[15:0];
      den = (sum >= 255) ? (510 - sum) : sum;
      q = (longint'(d) << 16) / den;
      res.sat = (q > 65535) ? 16'hFFFF : q[15:0];
    end
    return res;
  endfunction

  task automatic push_pixel(int unsigned r, g, b, a);
    pixel_q.push_back({a[7:0], b[7:0], g[7:0], r[7:0]});
  endtask

  task automatic push_random(int unsigned count);
    int unsigned r, g, b, base, pick;
    repeat (count) begin
      pick = $urandom_range(99);
      r = $urandom_range(255);
      g = $urandom_range(255);
      b = $urandom_range(255);
      if (pick < 15) begin
        // near grey
        base = $urandom_range(251);
        r = base + $urandom_range(4);
        g = base + $urandom_range(4);
        b = base + $urandom_range(4);
      end else if (pick < 30) begin
        // two channels equal
        case ($urandom_range(2))
          0: g = r;
          1: b = g;
          default: b = r;
        endcase
      end
      push_pixel(r, g, b, $urandom_range(255));
    end
  endtask

  task automatic drain_source();
    while (pixel_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
  endtask

  // driver: presents pending words, logs each accepted one as an expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) hsl_q.push_back(hsl_of(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata <= pixel_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each delivered word, drives back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    hsl_t exp_w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (hsl_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected word %h", m_axis_tdata);
        end else begin
          exp_w = hsl_q.pop_front();
          if (m_axis_tdata[15:0] !== exp_w.hue || m_axis_tdata[31:16] !== exp_w.sat ||
              m_axis_tdata[40:32] !== exp_w.lsum || m_axis_tdata[48:41] !== exp_w.alpha ||
              m_axis_tdata[55:49] !== 7'd0) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d pad %0d",
                       exp_w.hue, exp_w.sat, exp_w.lsum, exp_w.alpha,
                       m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[40:32],
                       m_axis_tdata[48:41], m_axis_tdata[55:49]);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #1 rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: greys, pure and tied primaries, sextant edges, lightness boundary
    push_pixel(0, 0, 0, 0);
    push_pixel(255, 255, 255, 255);
    push_pixel(128, 128, 128, 8'h5A);
    push_pixel(255, 0, 0, 8'hA5);
    push_pixel(0, 255, 0, 1);
    push_pixel(0, 0, 255, 254);
    push_pixel(255, 255, 0, 0);
    push_pixel(0, 255, 255, 255);
    push_pixel(255, 0, 255, 8'h80);
    push_pixel(200, 50, 100, 8'h7F);
    push_pixel(200, 100, 50, 3);
    push_pixel(10, 200, 30, 200);
    push_pixel(30, 10, 200, 17);
    push_pixel(255, 254, 254, 255);
    push_pixel(1, 0, 0, 0);
    push_pixel(254, 255, 255, 9);
    push_pixel(255, 1, 0, 40);
    push_pixel(255, 0, 1, 41);
    push_pixel(100, 150, 200, 8'hC3);
    push_pixel(200, 220, 240, 8'h3C);
    push_pixel(127, 128, 0, 8'h55);
    push_pixel(128, 127, 255, 8'hAA);
    push_random(475);
    drain_source();

    send_idle_pct = 49;
    push_random(475);
    drain_source();

    send_idle_pct = 0;
    recv_stall_pct = 49;
    push_random(475);
    drain_source();

    send_idle_pct = 38;
    recv_stall_pct = 38;
    push_random(475);
    drain_source();

    recv_stall_pct = 0;
    while (hsl_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0 && hsl_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
